// ===== rtl/msqrt_pkg.sv =====
// Shared constants, types and the modular add helper for the modular square root block.
package msqrt_pkg;

  localparam int Width  = 32;
  localparam int RootW  = 31;
  localparam int ZLimit = 4096;
  localparam int ZW     = $clog2(ZLimit) + 1;
  localparam int CntW   = $clog2(Width + 1);
  localparam int SW     = $clog2(Width) + 1;

  typedef logic [Width-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
  } mm_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t res;
  } mm_rsp_t;

  // (u + v) mod m for u, v < m
  function automatic word_t add_mod(word_t u, word_t v, word_t m);
    logic [Width:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[Width-1:0];
  endfunction

endpackage

// ===== rtl/modular_square_root.sv =====
// Top level: Tonelli-Shanks sequencer around a shared bit-serial modular multiplier.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+-----------------------
//  input   | in_value, in_modulus               | in_valid / in_stall
//  result  | out_root, out_not_residue          | out_valid / out_stall
//
// Every modular product runs on the one shared multiplier; an exponentiation
// costs up to 2*WIDTH products, so the work per item grows from a bad modulus
// (no products) through p = 3 mod 4 to p = 1 mod 4, and is largest when a
// composite modulus runs the z search to its limit.
// Reset is synchronous and clears control state only.
// in_stall is high while an item is at work; a stalled result holds in the
// output register while the next item is already being computed.
module modular_square_root (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [msqrt_pkg::Width-1:0]  in_value,
  input  logic [msqrt_pkg::Width-1:0]  in_modulus,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [msqrt_pkg::RootW-1:0]  out_root,
  output logic                         out_not_residue
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_RED    = 5'd1;
  localparam logic [4:0] ST_PCHK   = 5'd2;
  localparam logic [4:0] ST_PWA    = 5'd3;
  localparam logic [4:0] ST_PWB    = 5'd4;
  localparam logic [4:0] ST_EUL    = 5'd5;
  localparam logic [4:0] ST_SETR3  = 5'd6;
  localparam logic [4:0] ST_QS     = 5'd7;
  localparam logic [4:0] ST_ZCHK   = 5'd8;
  localparam logic [4:0] ST_ZRES   = 5'd9;
  localparam logic [4:0] ST_GC     = 5'd10;
  localparam logic [4:0] ST_GR     = 5'd11;
  localparam logic [4:0] ST_GT     = 5'd12;
  localparam logic [4:0] ST_LOOP   = 5'd13;
  localparam logic [4:0] ST_TTW    = 5'd14;
  localparam logic [4:0] ST_TTCHK  = 5'd15;
  localparam logic [4:0] ST_BSQ    = 5'd16;
  localparam logic [4:0] ST_BSQW   = 5'd17;
  localparam logic [4:0] ST_RBW    = 5'd18;
  localparam logic [4:0] ST_CW     = 5'd19;
  localparam logic [4:0] ST_TW     = 5'd20;
  localparam logic [4:0] ST_FIN    = 5'd21;

  localparam int W  = msqrt_pkg::Width;
  localparam int SW = msqrt_pkg::SW;
  localparam int ZW = msqrt_pkg::ZW;

  logic [4:0]        st_r, st_nxt;
  logic [4:0]        ret_r, ret_nxt;
  msqrt_pkg::word_t  p_r, p_nxt;
  msqrt_pkg::word_t  a_r, a_nxt;
  msqrt_pkg::word_t  e_r, e_nxt;
  msqrt_pkg::word_t  base_r, base_nxt;
  msqrt_pkg::word_t  acc_r, acc_nxt;
  msqrt_pkg::word_t  q_r, q_nxt;
  msqrt_pkg::word_t  c_r, c_nxt;
  msqrt_pkg::word_t  rt_r, rt_nxt;
  msqrt_pkg::word_t  t_r, t_nxt;
  msqrt_pkg::word_t  tt_r, tt_nxt;
  msqrt_pkg::word_t  b_r, b_nxt;
  logic [SW-1:0]     s_r, s_nxt;
  logic [SW-1:0]     m_r, m_nxt;
  logic [SW-1:0]     i_r, i_nxt;
  logic [SW-1:0]     k_r, k_nxt;
  logic [ZW-1:0]     z_r, z_nxt;
  logic              fail_r, fail_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [msqrt_pkg::RootW-1:0] out_root_r, out_root_nxt;
  logic              out_nr_r, out_nr_nxt;

  logic              pow_go;
  msqrt_pkg::word_t  pow_b;
  msqrt_pkg::word_t  pow_e;
  logic [4:0]        pow_ret;
  logic              red_start;
  logic              red_done;
  msqrt_pkg::word_t  red_rem;
  msqrt_pkg::mm_req_t mm_req;
  msqrt_pkg::mm_rsp_t mm_rsp;
  msqrt_pkg::word_t  pmr;
  msqrt_pkg::word_t  root_sel;
  logic [SW:0]       kip1;
  logic              in_acc;

  assign in_acc   = in_valid && (st_r == ST_IDLE);
  assign pmr      = p_r - rt_r;
  assign root_sel = (rt_r < pmr) ? rt_r : pmr;
  assign kip1     = {1'b0, k_r} + {1'b0, i_r} + (SW+1)'(1);

  msqrt_reduce u_red (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .a     (in_value),
    .p     (in_modulus),
    .done  (red_done),
    .rem   (red_rem)
  );

  msqrt_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .m     (p_r),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  always_comb begin
    st_nxt        = st_r;
    ret_nxt       = ret_r;
    p_nxt         = p_r;
    a_nxt         = a_r;
    e_nxt         = e_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    q_nxt         = q_r;
    c_nxt         = c_r;
    rt_nxt        = rt_r;
    t_nxt         = t_r;
    tt_nxt        = tt_r;
    b_nxt         = b_r;
    s_nxt         = s_r;
    m_nxt         = m_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    z_nxt         = z_r;
    fail_nxt      = fail_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_root_nxt  = out_root_r;
    out_nr_nxt    = out_nr_r;
    pow_go        = 1'b0;
    pow_b         = a_r;
    pow_e         = '0;
    pow_ret       = ST_FIN;
    red_start     = 1'b0;
    mm_req.start  = 1'b0;
    mm_req.x      = acc_r;
    mm_req.y      = base_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          p_nxt    = in_modulus;
          fail_nxt = 1'b0;
          if (in_modulus < W'(3) || !in_modulus[0]) begin
            fail_nxt = 1'b1;
            st_nxt   = ST_FIN;
          end else begin
            red_start = 1'b1;
            st_nxt    = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (red_done) begin
          a_nxt   = red_rem;
          pow_go  = 1'b1;
          pow_b   = red_rem;
          pow_e   = (p_r - W'(1)) >> 1;
          pow_ret = ST_EUL;
        end
      end
      ST_PCHK: begin
        if (e_r == '0) begin
          st_nxt = ret_r;
        end else if (e_r[0]) begin
          mm_req.start = 1'b1;
          st_nxt       = ST_PWA;
        end else begin
          mm_req.start = 1'b1;
          mm_req.x     = base_r;
          st_nxt       = ST_PWB;
        end
      end
      ST_PWA: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.res;
          e_nxt   = {e_r[W-1:1], 1'b0};
          st_nxt  = ST_PCHK;
        end
      end
      ST_PWB: begin
        if (mm_rsp.done) begin
          base_nxt = mm_rsp.res;
          e_nxt    = e_r >> 1;
          st_nxt   = ST_PCHK;
        end
      end
      ST_EUL: begin
        if (acc_r != W'(1)) begin
          fail_nxt = 1'b1;
          st_nxt   = ST_FIN;
        end else if (p_r[1]) begin
          pow_go  = 1'b1;
          pow_e   = (p_r >> 2) + W'(1);
          pow_ret = ST_SETR3;
        end else begin
          q_nxt  = p_r - W'(1);
          s_nxt  = '0;
          st_nxt = ST_QS;
        end
      end
      ST_SETR3: begin
        rt_nxt = acc_r;
        st_nxt = ST_FIN;
      end
      ST_QS: begin
        if (!q_r[0]) begin
          q_nxt = q_r >> 1;
          s_nxt = s_r + 1'b1;
        end else begin
          z_nxt  = ZW'(2);
          st_nxt = ST_ZCHK;
        end
      end
      ST_ZCHK: begin
        if (z_r < ZW'(msqrt_pkg::ZLimit) && W'(z_r) < p_r) begin
          pow_go  = 1'b1;
          pow_b   = W'(z_r);
          pow_e   = (p_r - W'(1)) >> 1;
          pow_ret = ST_ZRES;
        end else begin
          fail_nxt = 1'b1;
          st_nxt   = ST_FIN;
        end
      end
      ST_ZRES: begin
        if (acc_r == p_r - W'(1)) begin
          pow_go  = 1'b1;
          pow_b   = W'(z_r);
          pow_e   = q_r;
          pow_ret = ST_GC;
        end else begin
          z_nxt  = z_r + 1'b1;
          st_nxt = ST_ZCHK;
        end
      end
      ST_GC: begin
        c_nxt   = acc_r;
        pow_go  = 1'b1;
        pow_e   = (q_r >> 1) + W'(1);
        pow_ret = ST_GR;
      end
      ST_GR: begin
        rt_nxt  = acc_r;
        pow_go  = 1'b1;
        pow_e   = q_r;
        pow_ret = ST_GT;
      end
      ST_GT: begin
        t_nxt  = acc_r;
        m_nxt  = s_r;
        st_nxt = ST_LOOP;
      end
      ST_LOOP: begin
        if (t_r == W'(1)) begin
          st_nxt = ST_FIN;
        end else begin
          i_nxt        = SW'(1);
          mm_req.start = 1'b1;
          mm_req.x     = t_r;
          mm_req.y     = t_r;
          st_nxt       = ST_TTW;
        end
      end
      ST_TTW: begin
        if (mm_rsp.done) begin
          tt_nxt = mm_rsp.res;
          st_nxt = ST_TTCHK;
        end
      end
      ST_TTCHK: begin
        if (tt_r != W'(1)) begin
          if ({1'b0, i_r} + (SW+1)'(1) >= {1'b0, m_r}) begin
            fail_nxt = 1'b1;
            st_nxt   = ST_FIN;
          end else begin
            mm_req.start = 1'b1;
            mm_req.x     = tt_r;
            mm_req.y     = tt_r;
            i_nxt        = i_r + 1'b1;
            st_nxt       = ST_TTW;
          end
        end else if (i_r >= m_r) begin
          fail_nxt = 1'b1;
          st_nxt   = ST_FIN;
        end else begin
          b_nxt  = c_r;
          k_nxt  = '0;
          st_nxt = ST_BSQ;
        end
      end
      ST_BSQ: begin
        mm_req.start = 1'b1;
        if (kip1 < {1'b0, m_r}) begin
          mm_req.x = b_r;
          mm_req.y = b_r;
          k_nxt    = k_r + 1'b1;
          st_nxt   = ST_BSQW;
        end else begin
          mm_req.x = rt_r;
          mm_req.y = b_r;
          st_nxt   = ST_RBW;
        end
      end
      ST_BSQW: begin
        if (mm_rsp.done) begin
          b_nxt  = mm_rsp.res;
          st_nxt = ST_BSQ;
        end
      end
      ST_RBW: begin
        if (mm_rsp.done) begin
          rt_nxt       = mm_rsp.res;
          mm_req.start = 1'b1;
          mm_req.x     = b_r;
          mm_req.y     = b_r;
          st_nxt       = ST_CW;
        end
      end
      ST_CW: begin
        if (mm_rsp.done) begin
          c_nxt        = mm_rsp.res;
          mm_req.start = 1'b1;
          mm_req.x     = t_r;
          mm_req.y     = mm_rsp.res;
          st_nxt       = ST_TW;
        end
      end
      ST_TW: begin
        if (mm_rsp.done) begin
          t_nxt  = mm_rsp.res;
          m_nxt  = i_r;
          st_nxt = ST_LOOP;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nr_nxt    = fail_r;
          out_root_nxt  = fail_r ? '0 : root_sel[msqrt_pkg::RootW-1:0];
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (pow_go) begin
      acc_nxt  = W'(1);
      base_nxt = pow_b;
      e_nxt    = pow_e;
      ret_nxt  = pow_ret;
      st_nxt   = ST_PCHK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ret_r      <= ret_nxt;
    p_r        <= p_nxt;
    a_r        <= a_nxt;
    e_r        <= e_nxt;
    base_r     <= base_nxt;
    acc_r      <= acc_nxt;
    q_r        <= q_nxt;
    c_r        <= c_nxt;
    rt_r       <= rt_nxt;
    t_r        <= t_nxt;
    tt_r       <= tt_nxt;
    b_r        <= b_nxt;
    s_r        <= s_nxt;
    m_r        <= m_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    z_r        <= z_nxt;
    fail_r     <= fail_nxt;
    out_root_r <= out_root_nxt;
    out_nr_r   <= out_nr_nxt;
  end

  assign in_stall        = (st_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_root        = out_root_r;
  assign out_not_residue = out_nr_r;

  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier started while busy");

  a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !mm_rsp.busy)
    else $error("multiplier busy with no item at work");

  a_flag_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_not_residue) |-> (out_root == '0))
    else $error("root not zero with not_residue set");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (st_r != ST_IDLE))
    else $error("accepted item left no work in progress");

endmodule

// ===== rtl/msqrt_mulmod.sv =====
// Bit-serial modular multiplier: double then conditional add, one step per cycle.
module msqrt_mulmod (
  input  logic                  clk,
  input  logic                  rst_n,
  input  msqrt_pkg::word_t      m,
  input  msqrt_pkg::mm_req_t    req,
  output msqrt_pkg::mm_rsp_t    rsp
);

  msqrt_pkg::word_t                 x_r, x_nxt;
  msqrt_pkg::word_t                 y_r, y_nxt;
  msqrt_pkg::word_t                 acc_r, acc_nxt;
  logic [msqrt_pkg::CntW-1:0]       cnt_r, cnt_nxt;
  logic                             ph_r, ph_nxt;
  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    ph_nxt   = ph_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start && !busy_r) begin
      x_nxt    = req.x;
      y_nxt    = req.y;
      acc_nxt  = '0;
      cnt_nxt  = msqrt_pkg::CntW'(msqrt_pkg::Width);
      ph_nxt   = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!ph_r) begin
        acc_nxt = msqrt_pkg::add_mod(acc_r, acc_r, m);
        ph_nxt  = 1'b1;
      end else begin
        if (y_r[msqrt_pkg::Width-1]) begin
          acc_nxt = msqrt_pkg::add_mod(acc_r, x_r, m);
        end
        y_nxt   = {y_r[msqrt_pkg::Width-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        ph_nxt  = 1'b0;
        if (cnt_r == msqrt_pkg::CntW'(1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    ph_r  <= ph_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

// ===== rtl/msqrt_reduce.sv =====
// Bit-serial restoring remainder: value mod modulus, one bit per cycle.
module msqrt_reduce (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  msqrt_pkg::word_t  a,
  input  msqrt_pkg::word_t  p,
  output logic              done,
  output msqrt_pkg::word_t  rem
);

  msqrt_pkg::word_t             p_r, p_nxt;
  msqrt_pkg::word_t             sh_r, sh_nxt;
  msqrt_pkg::word_t             rem_r, rem_nxt;
  logic [msqrt_pkg::CntW-1:0]   cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [msqrt_pkg::Width:0]    t;

  always_comb begin
    p_nxt    = p_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    t        = {rem_r, sh_r[msqrt_pkg::Width-1]};
    if (start && !busy_r) begin
      p_nxt    = p;
      sh_nxt   = a;
      rem_nxt  = '0;
      cnt_nxt  = msqrt_pkg::CntW'(msqrt_pkg::Width);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (t >= {1'b0, p_r}) begin
        t = t - {1'b0, p_r};
      end
      rem_nxt = t[msqrt_pkg::Width-1:0];
      sh_nxt  = {sh_r[msqrt_pkg::Width-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == msqrt_pkg::CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    p_r   <= p_nxt;
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
